### hw/rtl/hlec_pkg.sv
// Package for the history line escape codec.
// Holds the shared constants, codes, character helpers and the result packet type.
// Depends on nothing; the codec modules and the bench import it.
package hlec_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W = 14;
  localparam int LIMIT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [LIMIT_W-1:0] COUNT_MAX = LIMIT_W'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd4096;

  localparam int MAX_RESULTS = 5;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W = $clog2(MAX_RESULTS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = LEN_W;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_OVERLONG = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam logic [4:0] DIGIT_BAD = 5'd16;

  typedef enum logic [1:0] {
    ESC_TEXT,
    ESC_BACKSLASH,
    ESC_HEX_HIGH,
    ESC_HEX_LOW
  } esc_phase_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    logic kind;
    logic [1:0] status;
    logic [MAX_RESULTS-1:0][7:0] bytes;
  } hlec_pkt_t;

  // Uppercase hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  // Value of a hex digit of either case, DIGIT_BAD for any other byte.
  function automatic logic [4:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd16;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end
    return v[4:0];
  endfunction

endpackage

### hw/rtl/hlec_in_if.sv
// Input channel of the history line escape codec: one byte per transaction.
// Depends on nothing.
interface hlec_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic end_of_line;
  modport source (output valid, output data_byte, output end_of_line, input ready);
  modport sink (input valid, input data_byte, input end_of_line, output ready);
endinterface

### hw/rtl/hlec_out_if.sv
// Result channel of the history line escape codec: one result per transaction.
// Depends on nothing.
interface hlec_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic kind;
  logic [1:0] status;
  logic last;
  modport source (output valid, output out_byte, output kind, output status, output last,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input status, input last,
                output ready);
endinterface

### hw/rtl/hlec_cfg_if.sv
// Configuration write channel of the history line escape codec.
// Depends on nothing; index and data widths match the package constants.
interface hlec_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [13:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/hlec_front.sv
// Front end of the codec: configuration registers, line state and byte classification.
// Builds one result packet per input byte. Depends on hlec_pkg and the channel interfaces.
module hlec_front
  import hlec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hlec_in_if.sink    feed,
  hlec_cfg_if.sink   cfg,
  input  logic       push_ready,
  output logic       push,
  output hlec_pkt_t  pkt
);

  logic mode;
  logic [LEN_W-1:0] max_len;
  esc_phase_t phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [LEN_W-1:0] plain_count, plain_count_next;
  logic [COUNT_WIDTH-1:0] encoded_count, encoded_count_next;
  logic corrupt_flag, corrupt_flag_next;
  logic overlong_flag, overlong_flag_next;

  logic accept, cfg_wr, keep, is_nl, at_limit;
  logic [LIMIT_W-1:0] limit_raw, limit;
  logic [4:0] digit;
  esc_phase_t d_phase;
  logic [3:0] d_high;
  logic d_bad, d_emit;
  logic [7:0] d_val;

  assign cfg.ready = 1'b1;
  assign cfg_wr = cfg.valid;
  assign feed.ready = push_ready;
  assign accept = feed.valid && push_ready;
  assign push = accept && (pkt.count != '0);

  assign keep = plain_count < max_len;
  assign is_nl = feed.data_byte == CH_NL;
  assign limit_raw = LIMIT_W'({max_len, 2'b00});
  assign limit = (limit_raw > COUNT_MAX) ? COUNT_MAX : limit_raw;
  assign at_limit = LIMIT_W'(encoded_count) >= limit;
  assign digit = digit_value(feed.data_byte);

  // Escape parser step for one decoded byte of a live line.
  always_comb begin
    d_phase = ESC_TEXT;
    d_high = high_nibble;
    d_bad = 1'b0;
    d_emit = 1'b0;
    d_val = feed.data_byte;
    case (phase)
      ESC_TEXT: begin
        if (feed.data_byte == CH_BACKSLASH) begin
          d_phase = ESC_BACKSLASH;
        end else if (feed.data_byte == CH_NUL) begin
          d_bad = 1'b1;
        end else begin
          d_emit = 1'b1;
        end
      end
      ESC_BACKSLASH: begin
        if (feed.data_byte == CH_BACKSLASH) begin
          d_emit = 1'b1;
        end else if (feed.data_byte == CH_LOWER_N) begin
          d_emit = 1'b1;
          d_val = CH_NL;
        end else if (feed.data_byte == CH_LOWER_T) begin
          d_emit = 1'b1;
          d_val = CH_TAB;
        end else if (feed.data_byte == CH_LOWER_X) begin
          d_phase = ESC_HEX_HIGH;
        end else begin
          d_bad = 1'b1;
        end
      end
      ESC_HEX_HIGH: begin
        if (digit == DIGIT_BAD) begin
          d_bad = 1'b1;
        end else begin
          d_high = digit[3:0];
          d_phase = ESC_HEX_LOW;
        end
      end
      ESC_HEX_LOW: begin
        d_high = 4'd0;
        if (digit == DIGIT_BAD || (high_nibble == 4'd0 && digit == 5'd0)) begin
          d_bad = 1'b1;
        end else begin
          d_emit = 1'b1;
          d_val = {high_nibble, digit[3:0]};
        end
      end
      default: begin
        d_bad = 1'b1;
      end
    endcase
  end

  // Next line state.
  always_comb begin
    phase_next = phase;
    high_nibble_next = high_nibble;
    plain_count_next = plain_count;
    encoded_count_next = encoded_count;
    corrupt_flag_next = corrupt_flag;
    overlong_flag_next = overlong_flag;
    if (mode == MODE_ENCODE) begin
      if (keep) begin
        plain_count_next = plain_count + 1'b1;
      end
      if (feed.end_of_line) begin
        phase_next = ESC_TEXT;
        high_nibble_next = 4'd0;
        plain_count_next = '0;
        encoded_count_next = '0;
        corrupt_flag_next = 1'b0;
        overlong_flag_next = 1'b0;
      end
    end else if (is_nl) begin
      phase_next = ESC_TEXT;
      high_nibble_next = 4'd0;
      plain_count_next = '0;
      encoded_count_next = '0;
      corrupt_flag_next = 1'b0;
      overlong_flag_next = 1'b0;
    end else if (!overlong_flag) begin
      if (at_limit) begin
        overlong_flag_next = 1'b1;
      end else begin
        encoded_count_next = encoded_count + 1'b1;
        if (!corrupt_flag) begin
          phase_next = d_phase;
          high_nibble_next = d_high;
          corrupt_flag_next = d_bad;
          if (d_emit && keep) begin
            plain_count_next = plain_count + 1'b1;
          end
        end
      end
    end
  end

  // Result packet for the byte on the input channel.
  always_comb begin
    pkt = '0;
    if (mode == MODE_ENCODE) begin
      if (keep) begin
        if (feed.data_byte == CH_BACKSLASH || feed.data_byte == CH_NL ||
            feed.data_byte == CH_TAB) begin
          pkt.bytes[0] = CH_BACKSLASH;
          pkt.bytes[1] = (feed.data_byte == CH_BACKSLASH) ? CH_BACKSLASH :
                         (feed.data_byte == CH_NL) ? CH_LOWER_N : CH_LOWER_T;
          pkt.count = RES_CNT_W'(2);
        end else if (feed.data_byte < CH_SPACE || feed.data_byte == CH_DEL) begin
          pkt.bytes[0] = CH_BACKSLASH;
          pkt.bytes[1] = CH_LOWER_X;
          pkt.bytes[2] = hex_char(feed.data_byte[7:4]);
          pkt.bytes[3] = hex_char(feed.data_byte[3:0]);
          pkt.count = RES_CNT_W'(4);
        end else begin
          pkt.bytes[0] = feed.data_byte;
          pkt.count = RES_CNT_W'(1);
        end
      end
      if (feed.end_of_line) begin
        pkt.bytes[RES_IDX_W'(pkt.count)] = CH_NL;
        pkt.count = pkt.count + 1'b1;
      end
    end else if (is_nl) begin
      pkt.kind = KIND_STATUS;
      pkt.count = RES_CNT_W'(1);
      if (overlong_flag) begin
        pkt.status = ST_OVERLONG;
      end else if (corrupt_flag || phase != ESC_TEXT) begin
        pkt.status = ST_CORRUPT;
      end else begin
        pkt.status = ST_GOOD;
      end
    end else if (!overlong_flag && !at_limit && !corrupt_flag && d_emit && keep) begin
      pkt.bytes[0] = d_val;
      pkt.count = RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      max_len <= MAX_LEN_RESET;
      phase <= ESC_TEXT;
      high_nibble <= 4'd0;
      plain_count <= '0;
      encoded_count <= '0;
      corrupt_flag <= 1'b0;
      overlong_flag <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg.index == REG_MODE) begin
        mode <= cfg.data[0];
        phase <= ESC_TEXT;
        high_nibble <= 4'd0;
        plain_count <= '0;
        encoded_count <= '0;
        corrupt_flag <= 1'b0;
        overlong_flag <= 1'b0;
      end else if (cfg.index == REG_MAX_LEN) begin
        max_len <= cfg.data;
      end
    end else if (accept) begin
      phase <= phase_next;
      high_nibble <= high_nibble_next;
      plain_count <= plain_count_next;
      encoded_count <= encoded_count_next;
      corrupt_flag <= corrupt_flag_next;
      overlong_flag <= overlong_flag_next;
    end
  end

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (push && pkt.kind == KIND_STATUS) |-> pkt.count == RES_CNT_W'(1))
    else $error("status packet must carry exactly one result");

endmodule

### hw/rtl/hlec_queue.sv
// Packet queue between the front end and the result sequencer of the codec.
// Depends on hlec_pkg for the packet type and the queue depth.
module hlec_queue
  import hlec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hlec_pkt_t  push_pkt,
  output logic       push_ready,
  output logic       pop_valid,
  input  logic       pop,
  output hlec_pkt_t  pop_pkt
);

  hlec_pkt_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0] level;

  assign push_ready = level != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid = level != '0;
  assign pop_pkt = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_level_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> level == $past(level) + 1'b1)
    else $error("queue level did not grow on a lone push");

endmodule

### hw/rtl/hlec_back.sv
// Result sequencer: unpacks queued packets into one result per cycle if result.ready.
// Depends on hlec_pkg and the result channel interface.
module hlec_back
  import hlec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  input  hlec_pkt_t  pop_pkt,
  output logic       pop,
  hlec_out_if.source result
);

  logic busy;
  hlec_pkt_t cur;
  logic [RES_IDX_W-1:0] idx;
  logic at_last, done;

  assign at_last = RES_CNT_W'(idx) == cur.count - 1'b1;
  assign done = result.ready && at_last;
  assign pop = pop_valid && (!busy || done);

  assign result.valid = busy;
  assign result.out_byte = cur.bytes[idx];
  assign result.kind = cur.kind;
  assign result.status = cur.status;
  assign result.last = at_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && done) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (busy && result.ready) begin
      idx <= idx + 1'b1;
    end
  end

  a_idx_in_packet: assert property (@(posedge clk) disable iff (rst)
    busy |-> (RES_CNT_W'(idx) < cur.count))
    else $error("result index beyond packet length");

  a_pop_loads_first: assert property (@(posedge clk) disable iff (rst)
    pop |=> (busy && idx == '0))
    else $error("a popped packet must start at its first result");

endmodule

### hw/rtl/history_line_escape_codec.sv
// Top level of the history line escape codec; depends on hlec_pkg, the channel interfaces,
// hlec_front, hlec_queue and hlec_back.
// The front end takes one input byte per cycle whenever the four-entry packet queue has
// room and turns it into zero to five results; the back end delivers one result per cycle
// while the result channel is ready. A plain byte yields one result, a two-byte escape two,
// a hex escape four, and a line end one more, so the input rate follows the output side:
// one byte per cycle for text without escapes, less for escaped bytes and line ends.
// Configuration writes are taken at any time and must only come while the block is idle;
// writing mode clears all line state. There is no start-up clearing pass.
module history_line_escape_codec
  import hlec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hlec_in_if.sink     feed,
  hlec_out_if.source  result,
  hlec_cfg_if.sink    cfg
);

  logic push, push_ready, pop, pop_valid;
  hlec_pkt_t push_pkt, pop_pkt;

  hlec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push       (push),
    .pkt        (push_pkt)
  );

  hlec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_pkt    (pop_pkt)
  );

  hlec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_pkt   (pop_pkt),
    .pop       (pop),
    .result    (result)
  );

endmodule

### bench/history_line_escape_codec_tb.sv
// Testbench for history_line_escape_codec: streams line bytes in encode and decode mode.
// A line codec kept in the bench predicts every result; a monitor compares each one by field.
// Depends on hlec_pkg and the hlec_in_if, hlec_out_if and hlec_cfg_if interfaces.
module history_line_escape_codec_tb;
  import hlec_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT = 2_000_000;
  localparam int PRINT_CAP = 200;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [0:15][7:0] HEX_UPPER = "0123456789ABCDEF";

  typedef struct packed {
    logic [7:0] data_byte;
    logic end_of_line;
  } feed_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic kind;
    logic [1:0] status;
    logic last;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic feed_valid = 1'b0;
  logic [7:0] feed_byte = 8'h00;
  logic feed_eol = 1'b0;
  logic result_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hlec_in_if feed_ch();
  hlec_out_if result_ch();
  hlec_cfg_if cfg_ch();

  assign feed_ch.valid = feed_valid;
  assign feed_ch.data_byte = feed_byte;
  assign feed_ch.end_of_line = feed_eol;
  assign result_ch.ready = result_ready;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.index = cfg_index;
  assign cfg_ch.data = cfg_data;

  history_line_escape_codec u_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  logic cur_mode;
  logic [LEN_W-1:0] cur_max_len;
  esc_phase_t esc_state;
  logic [3:0] held_nibble;
  logic [LEN_W-1:0] kept_count;
  int unsigned seen_count;
  logic line_corrupt;
  logic line_overlong;

  codec_result_t step_results[$];
  codec_result_t awaited_results[$];
  feed_item_t byte_backlog[$];

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;

  function automatic void clear_line_state();
    esc_state = ESC_TEXT;
    held_nibble = 4'h0;
    kept_count = '0;
    seen_count = 0;
    line_corrupt = 1'b0;
    line_overlong = 1'b0;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic k, input logic [1:0] s);
    codec_result_t r;
    r.out_byte = b;
    r.kind = k;
    r.status = s;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void keep_decoded(input logic [7:0] b);
    if (kept_count < cur_max_len) begin
      kept_count++;
      add_result(b, KIND_DATA, ST_GOOD);
    end
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    logic [4:0] v;
    v = DIGIT_BAD;
    if (b >= "0" && b <= "9") begin
      v = 5'(b - "0");
    end else if (b >= "A" && b <= "F") begin
      v = 5'(b - "A") + 5'd10;
    end else if (b >= "a" && b <= "f") begin
      v = 5'(b - "a") + 5'd10;
    end
    return v;
  endfunction

  function automatic void encode_plain(input logic [7:0] b, input logic eol);
    if (kept_count < cur_max_len) begin
      kept_count++;
      if (b == CH_BACKSLASH) begin
        add_result(CH_BACKSLASH, KIND_DATA, ST_GOOD);
        add_result(CH_BACKSLASH, KIND_DATA, ST_GOOD);
      end else if (b == CH_NL) begin
        add_result(CH_BACKSLASH, KIND_DATA, ST_GOOD);
        add_result(CH_LOWER_N, KIND_DATA, ST_GOOD);
      end else if (b == CH_TAB) begin
        add_result(CH_BACKSLASH, KIND_DATA, ST_GOOD);
        add_result(CH_LOWER_T, KIND_DATA, ST_GOOD);
      end else if (b < CH_SPACE || b == CH_DEL) begin
        add_result(CH_BACKSLASH, KIND_DATA, ST_GOOD);
        add_result(CH_LOWER_X, KIND_DATA, ST_GOOD);
        add_result(HEX_UPPER[b[7:4]], KIND_DATA, ST_GOOD);
        add_result(HEX_UPPER[b[3:0]], KIND_DATA, ST_GOOD);
      end else begin
        add_result(b, KIND_DATA, ST_GOOD);
      end
    end
    if (eol) begin
      add_result(CH_NL, KIND_DATA, ST_GOOD);
      clear_line_state();
    end
  endfunction

  function automatic void decode_escaped(input logic [7:0] b);
    int unsigned limit;
    logic [4:0] v;
    limit = 4 * cur_max_len;
    if (limit > COUNT_MAX) begin
      limit = COUNT_MAX;
    end
    if (b == CH_NL) begin
      if (line_overlong) begin
        add_result(8'h00, KIND_STATUS, ST_OVERLONG);
      end else if (line_corrupt || esc_state != ESC_TEXT) begin
        add_result(8'h00, KIND_STATUS, ST_CORRUPT);
      end else begin
        add_result(8'h00, KIND_STATUS, ST_GOOD);
      end
      clear_line_state();
    end else if (!line_overlong) begin
      if (seen_count >= limit) begin
        line_overlong = 1'b1;
      end else begin
        seen_count++;
        if (!line_corrupt) begin
          case (esc_state)
            ESC_TEXT: begin
              if (b == CH_BACKSLASH) begin
                esc_state = ESC_BACKSLASH;
              end else if (b == CH_NUL) begin
                line_corrupt = 1'b1;
              end else begin
                keep_decoded(b);
              end
            end
            ESC_BACKSLASH: begin
              esc_state = ESC_TEXT;
              if (b == CH_BACKSLASH) begin
                keep_decoded(CH_BACKSLASH);
              end else if (b == CH_LOWER_N) begin
                keep_decoded(CH_NL);
              end else if (b == CH_LOWER_T) begin
                keep_decoded(CH_TAB);
              end else if (b == CH_LOWER_X) begin
                esc_state = ESC_HEX_HIGH;
              end else begin
                line_corrupt = 1'b1;
              end
            end
            ESC_HEX_HIGH: begin
              v = nibble_of(b);
              if (v == DIGIT_BAD) begin
                line_corrupt = 1'b1;
                esc_state = ESC_TEXT;
              end else begin
                held_nibble = v[3:0];
                esc_state = ESC_HEX_LOW;
              end
            end
            default: begin
              v = nibble_of(b);
              esc_state = ESC_TEXT;
              if (v == DIGIT_BAD || (held_nibble == 4'h0 && v == 5'd0)) begin
                line_corrupt = 1'b1;
              end else begin
                keep_decoded({held_nibble, v[3:0]});
              end
              held_nibble = 4'h0;
            end
          endcase
        end
      end
    end
  endfunction

  function automatic void predict_results(input logic [7:0] b, input logic eol);
    step_results.delete();
    if (cur_mode == MODE_ENCODE) begin
      encode_plain(b, eol);
    end else begin
      decode_escaped(b);
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    foreach (step_results[i]) begin
      awaited_results.push_back(step_results[i]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH: %s", what);
    end
    mismatches++;
  endtask

  function automatic void send(input logic [7:0] b, input logic eol);
    feed_item_t it;
    it.data_byte = b;
    it.end_of_line = eol;
    byte_backlog.push_back(it);
    items_queued++;
  endfunction

  // In decode mode the end-of-line bit is ignored, so it is left random.
  function automatic void send_file_byte(input logic [7:0] b);
    send(b, 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: b = 8'($urandom_range(0, 255));
      2: b = CH_BACKSLASH;
      3: b = ($urandom_range(0, 1) != 0) ? CH_NL : CH_TAB;
      4: b = ($urandom_range(0, 1) != 0) ? CH_DEL : CH_NUL;
      5: b = 8'($urandom_range(0, 31));
      default: b = 8'($urandom_range(32, 126));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic lower);
    return HEX_UPPER[nib] | (lower ? 8'h20 : 8'h00);
  endfunction

  function automatic void send_hex_escape(input logic [7:0] b);
    logic lower;
    lower = 1'($urandom_range(0, 1));
    send_file_byte(CH_BACKSLASH);
    send_file_byte(CH_LOWER_X);
    send_file_byte(hex_digit(b[7:4], lower));
    send_file_byte(hex_digit(b[3:0], lower));
  endfunction

  function automatic void send_escaped(input logic [7:0] b);
    if (b == CH_BACKSLASH) begin
      send_file_byte(CH_BACKSLASH);
      send_file_byte(CH_BACKSLASH);
    end else if (b == CH_NL) begin
      send_file_byte(CH_BACKSLASH);
      send_file_byte(CH_LOWER_N);
    end else if (b == CH_TAB) begin
      send_file_byte(CH_BACKSLASH);
      send_file_byte(CH_LOWER_T);
    end else if (b < CH_SPACE || b == CH_DEL || $urandom_range(0, 7) == 0) begin
      send_hex_escape(b);
    end else begin
      send_file_byte(b);
    end
  endfunction

  // Some kinds of damage, placed at the end of a line, leave an escape open at the newline.
  function automatic void send_damage();
    case ($urandom_range(0, 6))
      0: send_file_byte(CH_NUL);
      1: send_hex_escape(CH_NUL);
      2: begin
        send_file_byte(CH_BACKSLASH);
        send_file_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        send_file_byte(CH_BACKSLASH);
        send_file_byte(CH_LOWER_X);
        send_file_byte(8'($urandom_range(0, 255)));
        send_file_byte(8'($urandom_range(0, 255)));
      end
      4: send_file_byte(8'($urandom_range(0, 255)));
      5: send_file_byte(CH_BACKSLASH);
      default: begin
        send_file_byte(CH_BACKSLASH);
        send_file_byte(CH_LOWER_X);
        send_file_byte(hex_digit(4'($urandom_range(0, 15)), 1'b0));
      end
    endcase
  endfunction

  function automatic void queue_escaped_line(input int unsigned n_plain, input logic damaged);
    int unsigned spot;
    logic [7:0] b;
    spot = $urandom_range(0, n_plain);
    for (int unsigned i = 0; i <= n_plain; i++) begin
      if (damaged && i == spot) begin
        send_damage();
      end
      if (i < n_plain) begin
        b = random_plain();
        if (b == CH_NUL) begin
          b = 8'h01;
        end
        send_escaped(b);
      end
    end
    send_file_byte(CH_NL);
  endfunction

  function automatic void queue_plain_line(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send(random_plain(), i == len - 1);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODE) begin
      cur_mode = value[0];
      clear_line_state();
    end else if (idx == REG_MAX_LEN) begin
      cur_max_len = value;
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_encode(input logic [LEN_W-1:0] len_cap, input int unsigned n_items);
    int unsigned target;
    write_reg(REG_MAX_LEN, len_cap);
    target = items_queued + n_items;
    while (items_queued < target) begin
      queue_plain_line($urandom_range(1, 9));
    end
    wait_idle();
  endtask

  task automatic random_decode(input logic [LEN_W-1:0] len_cap, input int unsigned n_items);
    int unsigned target;
    write_reg(REG_MAX_LEN, len_cap);
    target = items_queued + n_items;
    while (items_queued < target) begin
      queue_escaped_line($urandom_range(0, 6), $urandom_range(0, 3) == 0);
    end
    wait_idle();
  endtask

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    feed_item_t next_item;
    if (rst) begin
      feed_valid <= 1'b0;
    end else begin
      if (feed_valid && feed_ch.ready) begin
        predict_results(feed_byte, feed_eol);
        items_taken++;
      end
      if (!feed_valid || feed_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          feed_valid <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          next_item = byte_backlog.pop_front();
          feed_valid <= 1'b1;
          feed_byte <= next_item.data_byte;
          feed_eol <= next_item.end_of_line;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  int unsigned hold_left = 0;
  int unsigned stall_style = 0;
  int unsigned tick = 0;

  always @(posedge clk) begin
    tick++;
    if (tick % 97 == 0) begin
      stall_style = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      result_ready <= 1'b0;
    end else begin
      case (stall_style)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 3) != 0);
        2: result_ready <= (tick % 3 == 0);
        default: result_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && result_ch.valid && result_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d unexpected: byte %02h kind %0d status %0d",
                                  results_seen, result_ch.out_byte, result_ch.kind,
                                  result_ch.status));
      end else begin
        want = awaited_results.pop_front();
        if (result_ch.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                    results_seen, result_ch.out_byte, want.out_byte));
        end
        if (result_ch.kind !== want.kind) begin
          report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                    results_seen, result_ch.kind, want.kind));
        end
        if (result_ch.status !== want.status) begin
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, result_ch.status, want.status));
        end
        if (result_ch.last !== want.last) begin
          report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                    results_seen, result_ch.last, want.last));
        end
      end
    end
  end

  initial begin
    cur_mode = MODE_ENCODE;
    cur_max_len = MAX_LEN_RESET;
    clear_line_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_MODE, MODE_ENCODE);
    send(CH_NUL, 1'b0);
    send(CH_BACKSLASH, 1'b0);
    send(CH_NL, 1'b0);
    send(CH_TAB, 1'b0);
    send(CH_DEL, 1'b0);
    send(8'hFF, 1'b1);
    wait_idle();

    // With a one-byte cap the second byte is dropped but the line still closes.
    write_reg(REG_MAX_LEN, 14'd1);
    send("a", 1'b0);
    send("b", 1'b1);
    wait_idle();

    random_encode(14'd3, 22);
    holds_asked++;
    random_encode(14'd16383, 22);
    random_encode(14'($urandom_range(1, 12)), 22);

    write_reg(REG_MODE, MODE_DECODE);
    write_reg(REG_MAX_LEN, 14'd16383);
    send(CH_BACKSLASH, 1'b1);
    send(CH_LOWER_X, 1'b0);
    send("4", 1'b0);
    send("a", 1'b0);
    send(CH_BACKSLASH, 1'b0);
    send(CH_LOWER_T, 1'b0);
    send(CH_BACKSLASH, 1'b0);
    send("q", 1'b0);
    send("Z", 1'b0);
    send(CH_NL, 1'b0);
    wait_idle();

    // An escape left open is dropped when mode is written again.
    send(CH_BACKSLASH, 1'b0);
    send(CH_LOWER_X, 1'b0);
    send("4", 1'b0);
    wait_idle();
    write_reg(REG_MODE, MODE_DECODE);
    send("1", 1'b0);
    send(CH_NL, 1'b0);
    wait_idle();

    write_reg(REG_UNUSED, 14'h3FFF);
    write_reg(REG_MAX_LEN, 14'd1);
    // A zero byte spoils the line, then the fifth byte runs past the limit of four.
    send("a", 1'b0);
    send(CH_NUL, 1'b0);
    send("c", 1'b0);
    send("d", 1'b0);
    send("e", 1'b0);
    send(CH_NL, 1'b0);
    wait_idle();

    random_decode(14'd16383, 18);
    random_decode(14'd1, 18);
    random_decode(14'd2, 18);
    random_decode(14'($urandom_range(1, 12)), 18);

    write_reg(REG_MODE, MODE_ENCODE);
    random_encode(14'($urandom_range(1, 12)), 12);

    if (mismatches == 0) begin
      $display("history_line_escape_codec test passed");
    end else begin
      $display("history_line_escape_codec test failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("history_line_escape_codec test failed");
    $finish;
  end

endmodule
